### hw/rtl/bedf_pkg.sv
`timescale 1ns / 1ps

package bedf_pkg;

	localparam int PIXEL_BITS   = 8;
	localparam int QP_W         = 8;
	localparam int FLAT_DIFF_W  = 8;
	localparam int FLAT_COUNT_W = 4;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_INDEX_W  = 1;

	localparam int NUM_PIX   = 10;
	localparam int NUM_PAIRS = 8;
	localparam int NUM_MM    = NUM_PIX / 2;
	localparam int NUM_TAPS  = 9;
	localparam int NUM_EXT   = 16;

	// edge sum 2a-5b+5c-2d spans +-7 * pixel max
	localparam int EDGE_W = PIXEL_BITS + 4;
	// edge term after truncating divide by 8
	localparam int TERM_W = PIXEL_BITS + 1;
	// weighted smooth sum, weights add up to 16
	localparam int SUM_W  = PIXEL_BITS + 4;
	// five times the correction difference
	localparam int D5_W   = PIXEL_BITS + 4;

	localparam logic [CFG_INDEX_W-1:0] REG_FLAT_DIFF_LIMIT  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FLAT_COUNT_LIMIT = 1'b1;

	localparam logic [FLAT_DIFF_W-1:0]  FLAT_DIFF_RESET  = 8'd2;
	localparam logic [FLAT_COUNT_W-1:0] FLAT_COUNT_RESET = 4'd6;

	localparam logic [2:0] SMOOTH_TAPS [NUM_TAPS] = '{
		3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1
	};

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_SMOOTH  = 2'd1,
		MODE_DEFAULT = 2'd2
	} filter_mode_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_0;
		logic [PIXEL_BITS-1:0] pixel_1;
		logic [PIXEL_BITS-1:0] pixel_2;
		logic [PIXEL_BITS-1:0] pixel_3;
		logic [PIXEL_BITS-1:0] pixel_4;
		logic [PIXEL_BITS-1:0] pixel_5;
		logic [PIXEL_BITS-1:0] pixel_6;
		logic [PIXEL_BITS-1:0] pixel_7;
		logic [PIXEL_BITS-1:0] pixel_8;
		logic [PIXEL_BITS-1:0] pixel_9;
		logic [QP_W-1:0]       qp;
	} item_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] out_0;
		logic [PIXEL_BITS-1:0] out_1;
		logic [PIXEL_BITS-1:0] out_2;
		logic [PIXEL_BITS-1:0] out_3;
		logic [PIXEL_BITS-1:0] out_4;
		logic [PIXEL_BITS-1:0] out_5;
		logic [PIXEL_BITS-1:0] out_6;
		logic [PIXEL_BITS-1:0] out_7;
		logic [PIXEL_BITS-1:0] out_8;
		logic [PIXEL_BITS-1:0] out_9;
		filter_mode_t          filter_mode;
	} result_t;

endpackage

### hw/rtl/block_edge_deblocking_filter_unit.sv
`timescale 1ns / 1ps

// Block edge deblocking filter, three register stages.
// A transfer accepted on start passes the stage 1, stage 2 and stage 3 registers and then
// shows its result on result/done for a single cycle; the receiver takes it in that cycle.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall: each result is held for exactly one cycle.
// Reset (arst_n low, asynchronous) clears the stage valid bits and loads the
// flat limits with their defaults (difference 2, count 6).
module block_edge_deblocking_filter_unit
	import bedf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   start,
	output logic                   busy,
	input  item_t                  item,

	output logic                   done,
	output result_t                result
);

	localparam int PB = PIXEL_BITS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [FLAT_DIFF_W-1:0]  flat_diff_limit_q;
	logic [FLAT_COUNT_W-1:0] flat_count_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_diff_limit_q  <= FLAT_DIFF_RESET;
			flat_count_limit_q <= FLAT_COUNT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FLAT_DIFF_LIMIT: begin
					flat_diff_limit_q <= cfg_data[FLAT_DIFF_W-1:0];
				end
				REG_FLAT_COUNT_LIMIT: begin
					flat_count_limit_q <= cfg_data[FLAT_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Every cycle takes a new transfer; nothing upstream ever waits.
	assign busy = 1'b0;

	function automatic logic [PB-1:0] abs_diff(input logic [PB-1:0] a, input logic [PB-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: flat flags, padding pixels, raw edge sums, pairwise max/min
	// ------------------------------------------------------------------
	logic [PB-1:0] pix_in [NUM_PIX];

	assign pix_in[0] = item.pixel_0;
	assign pix_in[1] = item.pixel_1;
	assign pix_in[2] = item.pixel_2;
	assign pix_in[3] = item.pixel_3;
	assign pix_in[4] = item.pixel_4;
	assign pix_in[5] = item.pixel_5;
	assign pix_in[6] = item.pixel_6;
	assign pix_in[7] = item.pixel_7;
	assign pix_in[8] = item.pixel_8;
	assign pix_in[9] = item.pixel_9;

	logic [NUM_PAIRS-1:0]     flat_c1;
	logic [PB-1:0]            lpad_c1;
	logic [PB-1:0]            rpad_c1;
	logic signed [EDGE_W-1:0] esum_c1 [3];
	logic [PB-1:0]            pmax_c1 [NUM_MM];
	logic [PB-1:0]            pmin_c1 [NUM_MM];

	always_comb begin
		logic signed [EDGE_W-1:0] e [NUM_PIX];
		for (int i = 0; i < NUM_PIX; i++) begin
			e[i] = $signed({4'b0000, pix_in[i]});
		end
		for (int i = 0; i < NUM_PAIRS; i++) begin
			flat_c1[i] = abs_diff(pix_in[i], pix_in[i+1]) <= PB'(flat_diff_limit_q);
		end
		lpad_c1 = (abs_diff(pix_in[1], pix_in[0]) < PB'(item.qp)) ? pix_in[0] : pix_in[1];
		rpad_c1 = (abs_diff(pix_in[9], pix_in[8]) < PB'(item.qp)) ? pix_in[9] : pix_in[8];
		for (int k = 0; k < 3; k++) begin
			esum_c1[k] = EDGE_W'(2 * e[2*k+1] - 5 * e[2*k+2] + 5 * e[2*k+3] - 2 * e[2*k+4]);
		end
		for (int j = 0; j < NUM_MM; j++) begin
			pmax_c1[j] = (pix_in[2*j] > pix_in[2*j+1]) ? pix_in[2*j] : pix_in[2*j+1];
			pmin_c1[j] = (pix_in[2*j] < pix_in[2*j+1]) ? pix_in[2*j] : pix_in[2*j+1];
		end
	end

	logic                     valid_s1;
	logic [PB-1:0]            pix_s1 [NUM_PIX];
	logic [QP_W-1:0]          qp_s1;
	logic [NUM_PAIRS-1:0]     flat_s1;
	logic [PB-1:0]            lpad_s1;
	logic [PB-1:0]            rpad_s1;
	logic signed [EDGE_W-1:0] esum_s1 [3];
	logic [PB-1:0]            pmax_s1 [NUM_MM];
	logic [PB-1:0]            pmin_s1 [NUM_MM];

	always_ff @(posedge clk) begin
		pix_s1  <= pix_in;
		qp_s1   <= item.qp;
		flat_s1 <= flat_c1;
		lpad_s1 <= lpad_c1;
		rpad_s1 <= rpad_c1;
		esum_s1 <= esum_c1;
		pmax_s1 <= pmax_c1;
		pmin_s1 <= pmin_c1;
	end

	// ------------------------------------------------------------------
	// Stage 2: flat count, range test, edge terms, smooth taps
	// ------------------------------------------------------------------
	logic                     smooth_sel_c2;
	logic                     range_ok_c2;
	logic                     a1_small_c2;
	logic signed [TERM_W-1:0] a1_c2;
	logic [PB-1:0]            mag_min_c2;
	logic [PB-1:0]            smooth_c2 [NUM_PIX];

	always_comb begin
		logic [FLAT_COUNT_W-1:0]  count;
		logic [PB-1:0]            vmax;
		logic [PB-1:0]            vmin;
		logic [PB:0]              qp2;
		logic signed [EDGE_W-1:0] adj;
		logic signed [TERM_W-1:0] a [3];
		logic signed [TERM_W-1:0] neg;
		logic [PB-1:0]            mag [3];
		logic [PB-1:0]            ext [NUM_EXT];
		logic [SUM_W-1:0]         acc;

		count = '0;
		for (int i = 0; i < NUM_PAIRS; i++) begin
			count = count + FLAT_COUNT_W'(flat_s1[i]);
		end
		smooth_sel_c2 = count >= flat_count_limit_q;

		vmax = pmax_s1[0];
		vmin = pmin_s1[0];
		for (int j = 1; j < NUM_MM; j++) begin
			if (pmax_s1[j] > vmax) begin
				vmax = pmax_s1[j];
			end
			if (pmin_s1[j] < vmin) begin
				vmin = pmin_s1[j];
			end
		end
		qp2 = (PB+1)'(qp_s1) << 1;
		range_ok_c2 = (PB+1)'(vmax - vmin) < qp2;

		// divide by 8, rounding toward zero: bias negatives by 7 before the shift
		for (int k = 0; k < 3; k++) begin
			adj    = esum_s1[k] + $signed(EDGE_W'(esum_s1[k][EDGE_W-1] ? 7 : 0));
			a[k]   = adj[EDGE_W-1:3];
			neg    = -a[k];
			mag[k] = a[k][TERM_W-1] ? neg[PB-1:0] : a[k][PB-1:0];
		end
		a1_c2       = a[1];
		a1_small_c2 = mag[1] < PB'(qp_s1);

		// ties keep the centre magnitude; any smaller wins
		mag_min_c2 = mag[1];
		if (mag[0] < mag_min_c2) begin
			mag_min_c2 = mag[0];
		end
		if (mag[2] < mag_min_c2) begin
			mag_min_c2 = mag[2];
		end

		// padded line: four left pads, pixels 1..8, four right pads
		for (int j = 0; j < NUM_EXT; j++) begin
			if (j < 4) begin
				ext[j] = lpad_s1;
			end else if (j > 11) begin
				ext[j] = rpad_s1;
			end else begin
				ext[j] = pix_s1[j-3];
			end
		end
		smooth_c2[0] = pix_s1[0];
		smooth_c2[9] = pix_s1[9];
		for (int n = 1; n < NUM_PIX - 1; n++) begin
			acc = '0;
			for (int m = 0; m < NUM_TAPS; m++) begin
				acc = acc + SUM_W'(SMOOTH_TAPS[m]) * SUM_W'(ext[n+m-1]);
			end
			smooth_c2[n] = acc[SUM_W-1:4];
		end
	end

	logic                     valid_s2;
	logic [PB-1:0]            pix_s2 [NUM_PIX];
	logic                     smooth_sel_s2;
	logic                     range_ok_s2;
	logic                     a1_small_s2;
	logic signed [TERM_W-1:0] a1_s2;
	logic [PB-1:0]            mag_min_s2;
	logic [PB-1:0]            smooth_s2 [NUM_PIX];

	always_ff @(posedge clk) begin
		pix_s2        <= pix_s1;
		smooth_sel_s2 <= smooth_sel_c2;
		range_ok_s2   <= range_ok_c2;
		a1_small_s2   <= a1_small_c2;
		a1_s2         <= a1_c2;
		mag_min_s2    <= mag_min_c2;
		smooth_s2     <= smooth_c2;
	end

	// ------------------------------------------------------------------
	// Stage 3: edge correction, clip, mode select into the output register
	// ------------------------------------------------------------------
	logic [PB-1:0] out_c3 [NUM_PIX];
	filter_mode_t  mode_c3;

	always_comb begin
		logic signed [TERM_W-1:0] mn_s;
		logic signed [TERM_W-1:0] ap;
		logic signed [TERM_W:0]   delta;
		logic signed [D5_W-1:0]   d5;
		logic signed [D5_W-1:0]   d5_adj;
		logic signed [PB:0]       d;
		logic signed [PB:0]       diff;
		logic signed [PB:0]       diff_adj;
		logic signed [PB:0]       h;
		logic signed [PB:0]       dc;
		logic signed [PB:0]       o4;
		logic signed [PB:0]       o5;

		mn_s = $signed({1'b0, mag_min_s2});
		if (a1_s2 > 0) begin
			ap = mn_s;
		end else if (a1_s2 < 0) begin
			ap = -mn_s;
		end else begin
			ap = '0;
		end
		delta  = (TERM_W+1)'(ap) - (TERM_W+1)'(a1_s2);
		d5     = (D5_W'(delta) <<< 2) + D5_W'(delta);
		d5_adj = d5 + $signed(D5_W'(d5[D5_W-1] ? 7 : 0));
		d      = d5_adj[D5_W-1:3];

		diff     = $signed({1'b0, pix_s2[4]}) - $signed({1'b0, pix_s2[5]});
		diff_adj = diff + $signed((PB+1)'(diff[PB] ? 1 : 0));
		h        = diff_adj >>> 1;

		// clip the correction toward zero by half the step across the edge
		if (diff > 0) begin
			if (d < 0) begin
				dc = '0;
			end else if (d > h) begin
				dc = h;
			end else begin
				dc = d;
			end
		end else if (diff < 0) begin
			if (d > 0) begin
				dc = '0;
			end else if (d < h) begin
				dc = h;
			end else begin
				dc = d;
			end
		end else begin
			dc = '0;
		end
		o4 = $signed({1'b0, pix_s2[4]}) - dc;
		o5 = $signed({1'b0, pix_s2[5]}) + dc;

		out_c3  = pix_s2;
		mode_c3 = MODE_NONE;
		if (smooth_sel_s2) begin
			if (range_ok_s2) begin
				out_c3  = smooth_s2;
				mode_c3 = MODE_SMOOTH;
			end
		end else if (a1_small_s2) begin
			out_c3[4] = o4[PB-1:0];
			out_c3[5] = o5[PB-1:0];
			mode_c3   = MODE_DEFAULT;
		end
	end

	logic    valid_s3;
	result_t result_s3;

	always_ff @(posedge clk) begin
		result_s3.out_0       <= out_c3[0];
		result_s3.out_1       <= out_c3[1];
		result_s3.out_2       <= out_c3[2];
		result_s3.out_3       <= out_c3[3];
		result_s3.out_4       <= out_c3[4];
		result_s3.out_5       <= out_c3[5];
		result_s3.out_6       <= out_c3[6];
		result_s3.out_7       <= out_c3[7];
		result_s3.out_8       <= out_c3[8];
		result_s3.out_9       <= out_c3[9];
		result_s3.filter_mode <= mode_c3;
	end

	// Advance the valid bits every cycle; the receiver takes each result as it appears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign done   = valid_s3;
	assign result = result_s3;

endmodule
